>>> rtl/siotp_pkg.sv
// Package for the serial I/O tank plant emulator: widths, register indexes,
// command codes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package siotp_pkg;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned REG_DATA_W = 24;
	localparam logic [REG_IDX_W-1:0] REG_FILL = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DRAIN = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEAT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COOL = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CAP = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_AMB = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SH = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_DENS = 3'd7;
	localparam logic [3:0] CMD_DWR = 4'h0;
	localparam logic [3:0] CMD_DRD = 4'h1;
	localparam logic [3:0] CMD_AWR = 4'h2;
	localparam logic [3:0] CMD_ARD = 4'h3;
	localparam logic [31:0] TEMP_RESET = 32'sd1441792;
	// width of the divide datapath (dividend below 2^53 in magnitude)
	localparam int unsigned DIV_W = 68;
	localparam int unsigned DIVISOR_W = 52;
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage
`default_nettype wire

>>> rtl/siotp_if.sv
// Valid/ready channel interfaces for the emulator: input items, result items
// and configuration writes. Depends on siotp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface siotp_in_if import siotp_pkg::*; ();
	logic valid;
	logic ready;
	logic req_type;
	logic [7:0] rx_byte;
	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface siotp_out_if import siotp_pkg::*; ();
	logic valid;
	logic ready;
	logic [7:0] tx_byte;
	logic last;
	modport source (output valid, output tx_byte, output last, input ready);
	modport sink (input valid, input tx_byte, input last, output ready);
endinterface

interface siotp_cfg_if import siotp_pkg::*; ();
	logic valid;
	logic ready;
	logic [REG_IDX_W-1:0] index;
	logic [REG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/siotp_div.sv
// Restoring divider, one quotient bit a cycle, signed dividend, unsigned
// divisor, quotient truncated toward zero. Depends on siotp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module siotp_div import siotp_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic signed [DIV_W-1:0]     dividend,
	input  wire logic        [DIVISOR_W-1:0] divisor,
	output div_ctl_t                         ctl,
	output logic signed [DIV_W-1:0]          quotient
);
	localparam int unsigned CNT_W = $clog2(DIV_W + 1);
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q, neg_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIVISOR_W:0] rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W:0] rem_sh;

	// shift in next dividend bit and try a subtraction
	assign rem_sh = {rem_q[DIVISOR_W-1:0], quo_q[DIV_W-1]};
	assign trial = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			neg_q <= dividend[DIV_W-1];
			quo_q <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIVISOR_W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign ctl.done = done_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without busy");
	a_no_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_q && busy_q)) else $error("divider busy and done together");
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("divider busy with zero count");
endmodule
`default_nettype wire

>>> rtl/serial_io_tank_plant_emulator_core.sv
// Top level of the serial I/O tank plant emulator: command decoder, plant
// state and tick sequencer. Depends on siotp_pkg, siotp_if, siotp_div.
`timescale 1ns / 1ps
`default_nettype none
// A command reply leaves one or two result items through the output
// register, and the next item is taken once the reply has been handed over.
// A plant tick updates the volume in ST_VOL; when the tank ends empty it goes
// straight to ST_FIN, otherwise the product vol*density*sh is built in the
// ST_VOL and ST_MUL multiply states, the temperature step then goes through
// the one-bit-a-cycle divider and is saturated when it is done; ST_FIN then
// refreshes the flags and the volume output and ST_OUT the temperature output.
// No item is accepted meanwhile. There is no clearing pass after reset.
module serial_io_tank_plant_emulator_core import siotp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	siotp_in_if.sink in_ch,
	siotp_out_if.source out_ch,
	siotp_cfg_if.sink cfg
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_VOL = 3'd1;
	localparam logic [2:0] ST_MUL = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_FIN = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	logic [2:0] state_q;
	logic [15:0] fill_q, drain_q, cap_q, sh_q, dens_q;
	logic signed [15:0] amb_q;
	logic [23:0] heat_q, cool_q;
	logic [7:0] buf_q [3];
	logic [1:0] cnt_q;
	logic [7:0] din_q;
	logic [15:0] ain_q [4];
	logic [19:0] vol_q;
	logic signed [31:0] temp_q;
	logic [3:0] flags_q;
	logic [15:0] aout_q [2];
	logic [31:0] prod_q;
	logic signed [DIV_W-1:0] num_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [7:0] tx0_q, tx1_q;
	logic two_q, ov_q;
	logic div_start;
	div_ctl_t div_ctl;
	logic signed [DIV_W-1:0] quo;

	logic acc;
	logic [1:0] idx;
	logic [7:0] c0;
	logic [15:0] dens_e, sh_e;
	logic signed [21:0] vol_n;
	logic [19:0] cap10;
	logic [19:0] vol_c;
	logic signed [33:0] dt;
	logic signed [33:0] t_next;
	logic [39:0] vol_rcp;
	logic [16:0] vol_whole;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = (state_q == ST_IDLE) && !ov_q;
	assign acc = in_ch.valid && in_ch.ready;
	assign idx = (cnt_q > 2'd2) ? 2'd0 : cnt_q;
	assign c0 = (idx == 2'd0) ? in_ch.rx_byte : buf_q[0];
	assign dens_e = (dens_q == '0) ? 16'd1 : dens_q;
	assign sh_e = (sh_q == '0) ? 16'd1 : sh_q;
	assign cap10 = 20'(cap_q) * 20'd10;

	// whole units of volume: reciprocal multiply by 2^23/10, exact below 2^22
	assign vol_rcp = 40'(vol_q) * 40'd838861;
	assign vol_whole = vol_rcp[39:23];

	// volume update with clamp
	always_comb begin
		vol_n = $signed({2'b0, vol_q});
		if (din_q[0]) vol_n = vol_n + $signed(22'(fill_q));
		if (din_q[1]) vol_n = vol_n - $signed(22'(drain_q));
		if (vol_n < 0) vol_c = '0;
		else if (vol_n > $signed({2'b0, cap10})) vol_c = cap10;
		else vol_c = vol_n[19:0];
	end

	siotp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(num_q), .divisor(dsr_q), .ctl(div_ctl), .quotient(quo)
	);
	assign div_start = (state_q == ST_DIV);

	// temperature saturation
	always_comb begin
		dt = (quo > DIV_W'(64'sd4294967296)) ? 34'sd4294967296 :
		     (quo < -DIV_W'(64'sd4294967296)) ? -34'sd4294967296 : 34'(quo);
		t_next = 34'(temp_q) + dt;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 16'd100; drain_q <= 16'd100;
			heat_q <= 24'd800000; cool_q <= 24'd800000;
			cap_q <= 16'd3000; amb_q <= 16'sd5632;
			sh_q <= 16'd256; dens_q <= 16'd1000;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FILL: fill_q <= cfg.data[15:0];
				REG_DRAIN: drain_q <= cfg.data[15:0];
				REG_HEAT: heat_q <= cfg.data;
				REG_COOL: cool_q <= cfg.data;
				REG_CAP: cap_q <= cfg.data[15:0];
				REG_AMB: amb_q <= cfg.data[15:0];
				REG_SH: sh_q <= cfg.data[15:0];
				default: dens_q <= cfg.data[15:0];
			endcase
		end
	end

	// command buffer payload
	always_ff @(posedge clk) begin
		if (acc && !in_ch.req_type) buf_q[idx] <= in_ch.rx_byte;
	end

	// sequencer, commands and plant state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0; din_q <= '0;
			ain_q[0] <= 16'd10; ain_q[1] <= 16'd40; ain_q[2] <= '0; ain_q[3] <= '0;
			vol_q <= '0; temp_q <= TEMP_RESET; flags_q <= '0;
			aout_q[0] <= '0; aout_q[1] <= '0;
			ov_q <= 1'b0; two_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (two_q) begin
					two_q <= 1'b0;
					tx0_q <= tx1_q;
				end else ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && in_ch.req_type) state_q <= ST_VOL;
					else if (acc) begin
						case (c0[7:4])
							CMD_DWR: if (idx >= 2'd1) begin
								din_q[c0[2:0]] <= in_ch.rx_byte != 8'd0;
								cnt_q <= '0;
							end else cnt_q <= idx + 2'd1;
							CMD_DRD: begin
								cnt_q <= '0; ov_q <= 1'b1; two_q <= 1'b0;
								tx0_q <= {7'd0, ~c0[2] & flags_q[c0[1:0]]};
							end
							CMD_AWR: if (idx == 2'd2) begin
								ain_q[c0[1:0]] <= {buf_q[1], in_ch.rx_byte};
								cnt_q <= '0;
							end else cnt_q <= idx + 2'd1;
							CMD_ARD: begin
								cnt_q <= '0; ov_q <= 1'b1; two_q <= 1'b1;
								tx0_q <= c0[1] ? 8'd0 : aout_q[c0[0]][15:8];
								tx1_q <= c0[1] ? 8'd0 : aout_q[c0[0]][7:0];
							end
							default: cnt_q <= '0;
						endcase
					end
				end
				ST_VOL: begin
					vol_q <= vol_c;
					prod_q <= 32'(dens_e) * 32'(sh_e);
					// numerator: power*2^24 - (T-Tamb)*2560000
					num_q <= DIV_W'((($signed({1'b0, heat_q}) & {25{din_q[2]}})
						- ($signed({1'b0, cool_q}) & {25{din_q[3]}})) * 68'sd16777216)
						- DIV_W'(($signed(34'(temp_q))
						- $signed(34'($signed({amb_q, 8'd0})))) * 68'sd2560000);
					if (vol_c == '0) begin
						temp_q <= {{8{amb_q[15]}}, amb_q, 8'd0};
						state_q <= ST_FIN;
					end else state_q <= ST_MUL;
				end
				ST_MUL: begin
					dsr_q <= DIVISOR_W'(prod_q) * DIVISOR_W'(vol_q);
					state_q <= ST_DIV;
				end
				ST_DIV: state_q <= ST_WAIT;
				ST_WAIT: if (div_ctl.done) begin
					if (t_next > 34'sd2147483647) temp_q <= 32'sh7fffffff;
					else if (t_next < -34'sd2147483648) temp_q <= 32'sh80000000;
					else temp_q <= t_next[31:0];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					flags_q[0] <= vol_q >= cap10;
					flags_q[1] <= vol_q != '0;
					flags_q[2] <= temp_q < $signed({ain_q[0], 16'd0});
					flags_q[3] <= temp_q > $signed({ain_q[1], 16'd0});
					aout_q[0] <= (vol_whole > 17'd32767) ? 16'h7fff : vol_whole[15:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// truncate toward zero then saturate
					if (temp_q > 32'sd2147418111) aout_q[1] <= 16'h7fff;
					else if (temp_q < -32'sd2147483647) aout_q[1] <= 16'h8000;
					else aout_q[1] <= 16'((temp_q + (temp_q[31] ? 32'sd65535 : 32'sd0))
						>>> 16);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.tx_byte = tx0_q;
	assign out_ch.last = !two_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_ch.req_type) |=> state_q == ST_VOL) else $error("tick lost");
	a_vol_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> vol_q <= cap10) else $error("volume over capacity");
endmodule
`default_nettype wire

>>> bench/tank_reply_checker.sv
// Checker for the tank plant emulator: tracks configuration writes and input
// items, predicts reply bytes and compares them. Depends on siotp_pkg, siotp_if.
`timescale 1ns / 1ps
`default_nettype none
module tank_reply_checker import siotp_pkg::*; (
	input wire logic clk,
	siotp_in_if in_ch,
	siotp_out_if out_ch,
	siotp_cfg_if cfg,
	output int fails,
	output int pending
);
	typedef struct packed {
		logic [7:0] tx_byte;
		logic last;
	} reply_t;

	// shadow configuration, reset values
	logic [15:0] fill_r = 16'd100;
	logic [15:0] drain_r = 16'd100;
	logic [23:0] heat_r = 24'd800000;
	logic [23:0] cool_r = 24'd800000;
	logic [15:0] cap_r = 16'd3000;
	logic signed [15:0] amb_r = 16'sd5632;
	logic [15:0] sh_r = 16'd256;
	logic [15:0] dens_r = 16'd1000;

	// shadow plant state
	logic [7:0] cmd_buf [3];
	int unsigned cmd_cnt = 0;
	logic [7:0] dig_in = 8'h00;
	logic [15:0] ana_in [4] = '{16'd10, 16'd40, 16'd0, 16'd0};
	longint vol = 0;
	longint temp = longint'(TEMP_RESET);
	logic [3:0] flags = 4'h0;
	logic [15:0] ana_out [2] = '{16'd0, 16'd0};

	reply_t replies_due [$];

	initial fails = 0;
	assign pending = replies_due.size();

	function automatic logic [15:0] clip16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// volume, temperature, flags and analog outputs for one plant tick
	task automatic plant_tick();
		longint cap10, amb, t, pw, num, dv, d, s;
		cap10 = longint'(cap_r) * 10;
		amb = longint'(amb_r) * 256;
		t = temp;
		if (dig_in[0]) vol += longint'(fill_r);
		if (dig_in[1]) vol -= longint'(drain_r);
		if (vol < 0) vol = 0;
		if (vol > cap10) vol = cap10;
		if (vol > 0) begin
			d = (dens_r == 0) ? 1 : longint'(dens_r);
			s = (sh_r == 0) ? 1 : longint'(sh_r);
			dv = vol * d * s;
			pw = 0;
			if (dig_in[2]) pw += longint'(heat_r);
			if (dig_in[3]) pw -= longint'(cool_r);
			num = pw * 64'sd16777216 - (t - amb) * 64'sd2560000;
			t = t + num / dv;
			if (t > 64'sd2147483647) t = 64'sd2147483647;
			if (t < -64'sd2147483648) t = -64'sd2147483648;
		end else begin
			t = amb;
		end
		temp = t;
		flags = 4'h0;
		if (vol >= cap10) flags[0] = 1'b1;
		if (vol > 0) flags[1] = 1'b1;
		if (t < longint'($signed(ana_in[0])) * 65536) flags[2] = 1'b1;
		if (t > longint'($signed(ana_in[1])) * 65536) flags[3] = 1'b1;
		ana_out[0] = clip16(vol / 10);
		ana_out[1] = clip16(t / 65536);
	endtask

	// command decoder for one serial byte
	task automatic serial_byte(input logic [7:0] b);
		logic [7:0] c;
		logic [15:0] v;
		if (cmd_cnt > 2) cmd_cnt = 0;
		cmd_buf[cmd_cnt] = b;
		cmd_cnt++;
		c = cmd_buf[0];
		case (c[7:4])
			CMD_DWR: begin
				if (cmd_cnt >= 2) begin
					dig_in[c[2:0]] = (cmd_buf[1] != 8'h00);
					cmd_cnt = 0;
				end
			end
			CMD_DRD: begin
				cmd_cnt = 0;
				replies_due.push_back('{tx_byte: {7'd0, (c[2] ? 1'b0 : flags[c[1:0]])},
					last: 1'b1});
			end
			CMD_AWR: begin
				if (cmd_cnt >= 3) begin
					ana_in[c[1:0]] = {cmd_buf[1], cmd_buf[2]};
					cmd_cnt = 0;
				end
			end
			CMD_ARD: begin
				cmd_cnt = 0;
				v = c[1] ? 16'h0000 : ana_out[c[0]];
				replies_due.push_back('{tx_byte: v[15:8], last: 1'b0});
				replies_due.push_back('{tx_byte: v[7:0], last: 1'b1});
			end
			default: cmd_cnt = 0;
		endcase
	endtask

	always @(posedge clk) begin
		reply_t exp_r;
		// configuration writes
		if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FILL: fill_r <= cfg.data[15:0];
				REG_DRAIN: drain_r <= cfg.data[15:0];
				REG_HEAT: heat_r <= cfg.data;
				REG_COOL: cool_r <= cfg.data;
				REG_CAP: cap_r <= cfg.data[15:0];
				REG_AMB: amb_r <= cfg.data[15:0];
				REG_SH: sh_r <= cfg.data[15:0];
				default: dens_r <= cfg.data[15:0];
			endcase
		end
		// accepted input item
		if (in_ch.valid && in_ch.ready) begin
			if (in_ch.req_type) plant_tick();
			else serial_byte(in_ch.rx_byte);
		end
		// accepted reply byte
		if (out_ch.valid && out_ch.ready) begin
			if (replies_due.size() == 0) begin
				$display("%0t unexpected reply: actual tx_byte %02h last %0b", $time,
					out_ch.tx_byte, out_ch.last);
				fails++;
			end else begin
				exp_r = replies_due.pop_front();
				if (out_ch.tx_byte !== exp_r.tx_byte) begin
					$display("%0t tx_byte mismatch: expected %02h actual %02h", $time,
						exp_r.tx_byte, out_ch.tx_byte);
					fails++;
				end
				if (out_ch.last !== exp_r.last) begin
					$display("%0t last mismatch: expected %0b actual %0b", $time,
						exp_r.last, out_ch.last);
					fails++;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> bench/serial_io_tank_plant_emulator_core_tb.sv
// Testbench top for the tank plant emulator: clock, reset, stimulus over
// several register settings and the verdict. Depends on siotp_pkg, siotp_if,
// tank_reply_checker and the core.
`timescale 1ns / 1ps
`default_nettype none
module serial_io_tank_plant_emulator_core_tb;
	import siotp_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int TICK_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fails;
	int pending;
	int cycles = 0;
	bit calm = 1'b0;

	siotp_in_if in_ch ();
	siotp_out_if out_ch ();
	siotp_cfg_if cfg ();

	serial_io_tank_plant_emulator_core uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	tank_reply_checker chk (
		.clk(clk), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
		.fails(fails), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("serial_io_tank_plant_emulator_core_tb failed");
			$finish;
		end
	end

	function automatic int idle_draw();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// reply side: random stall before each item
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = idle_draw();
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			@(negedge clk);
		end
	end

	// one input item; entered and left at a falling edge
	task automatic send_item(input logic is_tick, input logic [7:0] b);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.req_type = is_tick;
		in_ch.rx_byte = b;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(1'b0, b);
	endtask

	task automatic settle();
		in_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TICK_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [REG_DATA_W-1:0] val);
		cfg.index = idx;
		cfg.data = val;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic write_all(input logic [15:0] fill, input logic [15:0] drain,
			input logic [23:0] heat, input logic [23:0] cool, input logic [15:0] cap,
			input logic [15:0] amb, input logic [15:0] sh, input logic [15:0] dens);
		settle();
		write_reg(REG_FILL, 24'(fill));
		write_reg(REG_DRAIN, 24'(drain));
		write_reg(REG_HEAT, heat);
		write_reg(REG_COOL, cool);
		write_reg(REG_CAP, 24'(cap));
		write_reg(REG_AMB, 24'(amb));
		write_reg(REG_SH, 24'(sh));
		write_reg(REG_DENS, 24'(dens));
	endtask

	// one random command or noise; mostly well-formed commands
	task automatic random_item();
		int pick;
		logic [7:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			send_item(1'b1, 8'($urandom));
		end else if (pick < 50) begin
			v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
			send_byte({CMD_DWR, 4'($urandom)});
			send_byte(v);
		end else if (pick < 62) begin
			send_byte({CMD_DRD, 4'($urandom)});
		end else if (pick < 70) begin
			send_byte({CMD_AWR, 4'($urandom)});
			if ($urandom_range(0, 1)) begin
				v = 8'($urandom_range(0, 1) ? 8'h00 : 8'hFF);
				send_byte(v);
				send_byte(8'($urandom_range(0, 80)));
			end else begin
				send_byte(8'($urandom));
				send_byte(8'($urandom));
			end
		end else if (pick < 86) begin
			send_byte({CMD_ARD, 4'($urandom)});
		end else if (pick < 93) begin
			send_byte(8'($urandom_range(4, 15) << 4) | 8'($urandom_range(0, 15)));
		end else begin
			send_byte(8'($urandom));
		end
	endtask

	task automatic random_run(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
			if (i % 150 == 75) settle();
			random_item();
		end
		calm = 1'b0;
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.req_type = 1'b0;
		in_ch.rx_byte = 8'h00;
		cfg.valid = 1'b0;
		cfg.index = REG_FILL;
		cfg.data = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset state, every command, extremes, unknown commands
		for (int n = 0; n < 8; n++) send_byte({CMD_DRD, 4'(n)});
		for (int n = 0; n < 4; n++) send_byte({CMD_ARD, 4'(n)});
		send_item(1'b1, 8'hFF);
		send_byte({CMD_DWR, 4'h0}); send_byte(8'h01);
		send_byte({CMD_DWR, 4'hA}); send_byte(8'h80);
		send_item(1'b1, 8'h00);
		send_byte({CMD_ARD, 4'h0});
		send_byte(8'hF5);
		send_byte({CMD_AWR, 4'h1}); send_byte(8'h7F); send_byte(8'hFF);
		send_byte({CMD_AWR, 4'h0}); send_byte(8'h80); send_byte(8'h00);
		send_item(1'b1, 8'h00);
		send_byte({CMD_ARD, 4'hD});
		send_byte({CMD_DRD, 4'h1});
		send_byte(8'h47);

		// reset settings
		random_run(230);
		// largest values
		write_all(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'h7FFF,
			16'hFFFF, 16'hFFFF);
		random_run(190);
		// smallest values, zero capacity and divisors
		write_all(16'h0000, 16'h0000, 24'h000000, 24'h000000, 16'h0000, 16'h8000,
			16'h0000, 16'h0000);
		random_run(150);
		// hot and light liquid: temperature saturation
		write_all(16'd5, 16'd3, 24'hFFFFFF, 24'd1000, 16'hFFFF, 16'h8000, 16'd1, 16'd1);
		random_run(190);
		// tiny tank
		write_all(16'd1, 16'd1, 24'd50000, 24'd70000, 16'd1, 16'h1600, 16'd256, 16'd1);
		random_run(150);
		// random settings
		for (int p = 0; p < 3; p++) begin
			write_all(16'($urandom), 16'($urandom_range(0, 400)), 24'($urandom),
				24'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom),
				16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
			random_run(150);
		end

		settle();
		if (fails == 0) begin
			$display("serial_io_tank_plant_emulator_core_tb passed");
		end else begin
			$display("serial_io_tank_plant_emulator_core_tb failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> serial_io_tank_plant_emulator_core.f
rtl/siotp_pkg.sv
rtl/siotp_if.sv
rtl/siotp_div.sv
rtl/serial_io_tank_plant_emulator_core.sv
bench/tank_reply_checker.sv
bench/serial_io_tank_plant_emulator_core_tb.sv
